### rtl/b64e_pkg.sv
// shared types, constants and the alphabet function for the base64 stream encoder
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

	localparam int BYTE_W   = 8;
	localparam int CHAR_W   = 7;
	localparam int SEXTET_W = 6;
	localparam int GPL_W    = 6;

	localparam logic [GPL_W-1:0] GPL_RESET = 6'd19;

	localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_PAD   = 7'h3D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
	localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER = 7'h61;
	localparam logic [CHAR_W-1:0] CH_DIGIT = 7'h30;

	// character slots in one request: four group characters, then cr and lf
	localparam logic [2:0] IDX_CR       = 3'd4;
	localparam logic [2:0] IDX_LF       = 3'd5;
	localparam logic [2:0] IDX_LAST_GRP = 3'd3;

	// one encoded group as it travels from the front to the back
	typedef struct packed {
		logic [3:0][CHAR_W-1:0] chars;
		logic                   crlf;
		logic                   last;
	} b64e_job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} b64e_q_status_t;

	// standard alphabet lookup
	function automatic logic [CHAR_W-1:0] b64_sym(input logic [SEXTET_W-1:0] v);
		logic [CHAR_W-1:0] v7;
		logic [CHAR_W-1:0] r;
		v7 = {1'b0, v};
		if (v < 6'd26) begin
			r = v7 + CH_UPPER;
		end else if (v < 6'd52) begin
			r = v7 + CH_LOWER - 7'd26;
		end else if (v < 6'd62) begin
			r = v7 + CH_DIGIT - 7'd52;
		end else if (v == 6'd62) begin
			r = CH_PLUS;
		end else begin
			r = CH_SLASH;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/b64e_if.sv
// stream interfaces for message bytes and encoded characters
`timescale 1ns / 1ps
`default_nettype none

interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, data_byte, final_byte, input ready);
	modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source(output valid, out_char, last_char, input ready);
	modport sink(input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

### rtl/b64e_front.sv
// front end: collects bytes, forms groups and pushes encoded requests
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
	import b64e_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	b64e_byte_if.sink              msg,
	input  wire logic              cfg_we,
	input  wire logic [GPL_W-1:0]  cfg_data,
	input  wire b64e_q_status_t    q_stat,
	output logic                   push,
	output b64e_job_t              push_job
);

	logic [15:0]      pend_bytes_q;
	logic [1:0]       pend_cnt_q;
	logic [GPL_W-1:0] groups_q;
	logic [GPL_W-1:0] gpl_q;

	logic             accept;
	logic [7:0]       b, b1, b2;
	logic [GPL_W-1:0] groups_inc;
	logic             line_full;

	assign msg.ready = !q_stat.full;
	assign accept    = msg.valid && msg.ready;
	assign b         = msg.data_byte;
	assign b1        = pend_bytes_q[15:8];
	assign b2        = pend_bytes_q[7:0];
	assign groups_inc = groups_q + 6'd1;
	assign line_full  = groups_inc >= gpl_q;

	// line length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q <= GPL_RESET;
		end else if (cfg_we) begin
			gpl_q <= cfg_data;
		end
	end

	// classify the byte and build the request
	always_comb begin
		push          = 1'b0;
		push_job      = '0;
		push_job.last = msg.final_byte;
		if (pend_cnt_q == 2'd2) begin
			push              = accept;
			push_job.chars[0] = b64_sym(b1[7:2]);
			push_job.chars[1] = b64_sym({b1[1:0], b2[7:4]});
			push_job.chars[2] = b64_sym({b2[3:0], b[7:6]});
			push_job.chars[3] = b64_sym(b[5:0]);
			push_job.crlf     = line_full;
		end else if (msg.final_byte && pend_cnt_q == 2'd0) begin
			push              = accept;
			push_job.chars[0] = b64_sym(b[7:2]);
			push_job.chars[1] = b64_sym({b[1:0], 4'd0});
			push_job.chars[2] = CH_PAD;
			push_job.chars[3] = CH_PAD;
		end else if (msg.final_byte) begin
			push              = accept;
			push_job.chars[0] = b64_sym(b1[7:2]);
			push_job.chars[1] = b64_sym({b1[1:0], b[7:4]});
			push_job.chars[2] = b64_sym({b[3:0], 2'd0});
			push_job.chars[3] = CH_PAD;
		end
	end

	// pending bytes and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bytes_q <= '0;
			pend_cnt_q   <= '0;
			groups_q     <= '0;
		end else if (accept) begin
			if (pend_cnt_q == 2'd2) begin
				pend_cnt_q <= '0;
				groups_q   <= (line_full || msg.final_byte) ? '0 : groups_inc;
			end else if (!msg.final_byte) begin
				if (pend_cnt_q == 2'd0) begin
					pend_bytes_q[15:8] <= b;
				end else begin
					pend_bytes_q[7:0] <= b;
				end
				pend_cnt_q <= pend_cnt_q + 2'd1;
			end else begin
				pend_cnt_q <= '0;
				groups_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/b64e_queue.sv
// two-entry queue of encoded requests between front and back
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
	import b64e_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64e_job_t      push_job,
	input  wire logic           pop,
	output b64e_job_t           head,
	output b64e_q_status_t      stat
);

	b64e_job_t  mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/b64e_back.sv
// back end: walks each request out one character per cycle while code.ready is high
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
	import b64e_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b64e_job_t       head,
	input  wire b64e_q_status_t  q_stat,
	output logic                 pop,
	b64e_char_if.source          code
);

	b64e_job_t  job_q;
	logic       job_valid_q;
	logic [2:0] idx_q;

	logic       fire;
	logic [2:0] end_idx;
	logic       at_end;
	logic       load;

	assign end_idx = job_q.crlf ? IDX_LF : IDX_LAST_GRP;
	assign at_end  = idx_q == end_idx;
	assign fire    = code.valid && code.ready;
	assign load    = !job_valid_q || (fire && at_end);
	assign pop     = load && !q_stat.empty;

	// character select
	always_comb begin
		code.valid     = job_valid_q;
		code.last_char = job_q.last && at_end;
		case (idx_q)
			IDX_CR:  code.out_char = CH_CR;
			IDX_LF:  code.out_char = CH_LF;
			default: code.out_char = job_q.chars[idx_q[1:0]];
		endcase
	end

	// current request and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			job_valid_q <= !q_stat.empty;
			idx_q       <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= head;
		end
	end

endmodule

`default_nettype wire

### rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder with line wrapping
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 encoder: message bytes enter on msg, one per request, with
// final_byte on the last one; characters leave on code, one per cycle while
// code.ready is high, with last_char on the final character of the message.
// Every third byte yields four characters, plus CR LF once groups_per_line
// groups fill a line (19 at reset, 76 characters); a final byte with one or
// two bytes left yields a padded tail. The front takes a byte in every cycle
// while the two-entry request queue has room; the back drives one character
// per cycle, so in steady flow three bytes become four characters, or six at
// a line end. That single character port sets the sustained rate. cfg_data is
// written with cfg_we and should only change while the encoder is idle.
module base64_stream_encoder
	import b64e_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	b64e_byte_if.sink             msg,
	b64e_char_if.source           code,
	input  wire logic             cfg_we,
	input  wire logic [GPL_W-1:0] cfg_data
);

	b64e_q_status_t q_stat;
	b64e_job_t      push_job;
	b64e_job_t      head;
	logic           push;
	logic           pop;

	// byte intake and grouping
	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// request queue
	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// character output
	b64e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.code   (code)
	);

`ifndef NO_ASSERTIONS
	// queue cannot be full and empty at once
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty");

	// a line break never ends a message on cr
	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		code.valid && code.out_char == CH_CR |-> !code.last_char)
		else $error("cr flagged as last character");

	// lf follows cr right away
	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		code.valid && code.ready && code.out_char == CH_CR
		|=> code.valid && code.out_char == CH_LF)
		else $error("cr not followed by lf");

	// a full queue stays full until a request is popped
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !pop |=> !$rose(q_stat.empty) && q_stat.full)
		else $error("queue left full state without a pop");
`endif

endmodule

`default_nettype wire

### verif/b64e_checker.sv
// checker for the base64 stream encoder: predicts characters from accepted bytes and compares
`timescale 1ns / 1ps

module b64e_checker
	import b64e_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	b64e_byte_if                  msg,
	b64e_char_if                  code,
	input  wire logic             cfg_we,
	input  wire logic [GPL_W-1:0] cfg_data,
	output int                    outstanding,
	output int                    fail_count
);

	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} enc_char_t;

	enc_char_t expected_chars[$];

	// predictor state
	logic [GPL_W-1:0]  line_width;
	logic [BYTE_W-1:0] held_hi;
	logic [BYTE_W-1:0] held_lo;
	logic [1:0]        held_count;
	logic [GPL_W-1:0]  line_groups;

	function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
		return B64_ALPHABET[8 * (63 - int'(v)) +: CHAR_W];
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] b64e_checker: %s", $time, what);
		fail_count++;
	endtask

	// work out the characters one accepted byte produces and queue them
	function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [CHAR_W-1:0] seq [6];
		int                n;
		enc_char_t         item;
		n = 0;
		if (held_count == 2'd2) begin
			seq[0] = sextet_char(held_hi[7:2]);
			seq[1] = sextet_char({held_hi[1:0], held_lo[7:4]});
			seq[2] = sextet_char({held_lo[3:0], b[7:6]});
			seq[3] = sextet_char(b[5:0]);
			n = 4;
			line_groups = line_groups + 6'd1;
			if (line_groups >= line_width) begin
				seq[4] = CH_CR;
				seq[5] = CH_LF;
				n = 6;
				line_groups = '0;
			end
			held_count = 2'd0;
		end else if (!fin) begin
			if (held_count == 2'd0) begin
				held_hi = b;
			end else begin
				held_lo = b;
			end
			held_count = held_count + 2'd1;
		end else if (held_count == 2'd0) begin
			// one leftover byte: two characters and two pads
			seq[0] = sextet_char(b[7:2]);
			seq[1] = sextet_char({b[1:0], 4'h0});
			seq[2] = CH_PAD;
			seq[3] = CH_PAD;
			n = 4;
		end else begin
			// two leftover bytes: three characters and one pad
			seq[0] = sextet_char(held_hi[7:2]);
			seq[1] = sextet_char({held_hi[1:0], b[7:4]});
			seq[2] = sextet_char({b[3:0], 2'b00});
			seq[3] = CH_PAD;
			n = 4;
		end
		for (int i = 0; i < n; i++) begin
			item.ch   = seq[i];
			item.last = fin && (i == n - 1);
			expected_chars.insert(expected_chars.size(), item);
		end
		// a message end clears the pending bytes and the line position
		if (fin) begin
			held_count  = 2'd0;
			line_groups = '0;
		end
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		enc_char_t want;
		if (!arst_n) begin
			line_width  = GPL_RESET;
			held_hi     = '0;
			held_lo     = '0;
			held_count  = 2'd0;
			line_groups = '0;
			fail_count  = 0;
			expected_chars.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				line_width = cfg_data;
			end
			if (msg.valid && msg.ready) begin
				encode_byte(msg.data_byte, msg.final_byte);
			end
			if (code.valid && code.ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
						code.out_char, code.last_char));
				end else begin
					want = expected_chars.pop_front();
					if (code.out_char !== want.ch) begin
						report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
							code.out_char, want.ch));
					end
					if (code.last_char !== want.last) begin
						report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
							code.last_char, want.last, want.ch));
					end
				end
			end
			outstanding <= expected_chars.size();
		end
	end

endmodule

### verif/tb_base64_stream_encoder.sv
// testbench top for the base64 stream encoder: byte stimulus, output stalls and verdict
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
	import b64e_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [GPL_W-1:0] cfg_data;
	int               outstanding;
	int               fail_count;
	bit               src_gaps;
	bit               snk_stalls;

	b64e_byte_if msg_ch();
	b64e_char_if code_ch();

	base64_stream_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg_ch),
		.code     (code_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	b64e_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg         (msg_ch),
		.code        (code_ch),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("tb_base64_stream_encoder: FAIL");
		$finish;
	end

	// output side: ready with random stall bursts
	initial begin
		int stall;
		code_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (snk_stalls && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 15);
				code_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			code_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// offer one byte, with an optional gap before it, and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int   gap;
		logic taken;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			msg_ch.valid     <= 1'b0;
			msg_ch.data_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid      <= 1'b1;
		msg_ch.data_byte  <= b;
		msg_ch.final_byte <= fin;
		// ready only moves at a rising edge, so sample it mid-cycle
		do begin
			@(negedge clk);
			taken = msg_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_random_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom), i == len - 1);
		end
	endtask

	// drop valid and wait until every predicted character has come out
	task automatic drain();
		msg_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_line_width(input logic [GPL_W-1:0] w);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [GPL_W-1:0] width;
		int               budget;
		int               len;
		arst_n            <= 1'b0;
		msg_ch.valid      <= 1'b0;
		msg_ch.data_byte  <= '0;
		msg_ch.final_byte <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_data          <= GPL_RESET;
		src_gaps   = 1'b0;
		snk_stalls = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-byte tails, two-byte tail, group on the final byte
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);

		// directed: break after every group, line end on the final byte, tail after a break
		set_line_width(6'd1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);

		// random phases over several line widths, the extremes among them
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: width = 6'd1;
				1: width = 6'd63;
				2: width = 6'd2;
				3: width = 6'($urandom_range(3, 62));
				4: width = GPL_RESET;
				default: width = 6'($urandom_range(1, 8));
			endcase
			set_line_width(width);
			src_gaps   = (phase < 5) && ($urandom_range(0, 2) != 0);
			snk_stalls = (phase < 5) && ($urandom_range(0, 2) != 0);
			budget = 0;
			while (budget < 30) begin
				if (width <= 6'd20 && $urandom_range(0, 7) == 0) begin
					len = 3 * int'(width) + $urandom_range(0, 2);
				end else begin
					len = $urandom_range(1, 12);
				end
				send_random_message(len);
				budget += len;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_base64_stream_encoder: PASS");
		end else begin
			$display("tb_base64_stream_encoder: FAIL");
		end
		$finish;
	end

endmodule
